// ===== hdl/haversine_distance_macros.svh =====
// Concurrent assertion helpers, clocked on aclk and idle during reset.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// Same-cycle implication.
`define HVD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hvd_pkg.sv =====
package hvd_pkg;

    localparam int ANGLE_FRAC_BITS = 20;
    localparam int DIST_FRAC_BITS  = 16;

    localparam int LON_W  = 29;
    localparam int LAT_W  = 28;
    localparam int DIST_W = 31;

    localparam int Q_FRAC = 30;
    localparam int Q_W    = Q_FRAC + 1;
    localparam int ARG_W  = Q_FRAC + 1;
    localparam int RAD_W  = Q_FRAC + 2;
    localparam int SQ_W   = Q_FRAC + 2;

    localparam logic signed [LON_W-1:0] LON_LIM = LON_W'(180 <<< ANGLE_FRAC_BITS);
    localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 <<< ANGLE_FRAC_BITS);

    localparam int DEG_UP = (ANGLE_FRAC_BITS <= 24) ? 24 - ANGLE_FRAC_BITS : 0;
    localparam int DEG_DN = (ANGLE_FRAC_BITS > 24) ? ANGLE_FRAC_BITS - 24 : 0;
    localparam int DEG_W  = LON_W + 1 + DEG_UP;
    localparam logic [DEG_W-1:0] DEG_RND = DEG_W'((64'd1 << DEG_DN) >> 1);

    localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;
    localparam int PROD_W = DEG_W + 31;

    localparam logic [Q_W-1:0]   ONE_Q30     = Q_W'(64'd1 << Q_FRAC);
    localparam logic [RAD_W-1:0] PI_Q30      = RAD_W'(64'd3373259426);
    localparam logic [ARG_W-1:0] HALF_PI_Q30 = ARG_W'(64'd1686629713);

    localparam int SIN_STEPS = 6;
    localparam int SIN_M_W   = 34;
    localparam int SIN_K [SIN_STEPS] = '{41, 40, 40, 39, 38, 36};
    localparam logic [SIN_M_W-1:0] SIN_M [SIN_STEPS] = '{
        SIN_M_W'(((64'd1 << 41) + 64'd155) / 64'd156),
        SIN_M_W'(((64'd1 << 40) + 64'd109) / 64'd110),
        SIN_M_W'(((64'd1 << 40) + 64'd71) / 64'd72),
        SIN_M_W'(((64'd1 << 39) + 64'd41) / 64'd42),
        SIN_M_W'(((64'd1 << 38) + 64'd19) / 64'd20),
        SIN_M_W'(((64'd1 << 36) + 64'd5) / 64'd6)
    };

    localparam int ISQRT_STEPS  = Q_FRAC + 1;
    localparam int CORDIC_STEPS = Q_FRAC + 1;
    localparam int CORDIC_W     = Q_FRAC + 4;
    localparam int ANGLE_ACC_W  = Q_FRAC + 3;

    // round(atan(2^-i) * 2^30)
    localparam logic [Q_FRAC-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1
    };

    localparam int NUM_W = 48;
    localparam logic [16:0] DIAM_TENTHS = 17'd127456;
    localparam int DIST_DS = 31 - DIST_FRAC_BITS;
    localparam logic [NUM_W-1:0] DIST_HALF = NUM_W'(64'd5 << (30 - DIST_FRAC_BITS));
    localparam int DIST_QW = NUM_W + 1 - DIST_DS;
    localparam int DIST_RK = DIST_QW + 3;
    localparam int DIST_RW = DIST_RK - 2;
    localparam logic [DIST_RW-1:0] DIST_RECIP =
        DIST_RW'(((64'd1 << DIST_RK) + 64'd4) / 64'd5);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_HIGH = DIST_W'(64'd1312096256);

    typedef logic [Q_W-1:0]                q30_t;
    typedef logic [ARG_W-1:0]              arg_t;
    typedef logic signed [ANGLE_ACC_W-1:0] ang_t;

endpackage

// ===== hdl/hvd_front.sv =====
module hvd_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [hvd_pkg::LON_W-1:0]   lon_first,
    input  logic signed [hvd_pkg::LAT_W-1:0]   lat_first,
    input  logic signed [hvd_pkg::LON_W-1:0]   lon_second,
    input  logic signed [hvd_pkg::LAT_W-1:0]   lat_second,
    output logic                               out_valid,
    output hvd_pkg::arg_t                      arg_dlat,
    output hvd_pkg::arg_t                      arg_dlon,
    output hvd_pkg::arg_t                      arg_cos_first,
    output hvd_pkg::arg_t                      arg_cos_second
);
    import hvd_pkg::*;

    localparam int LOND_W = LON_W + 1;
    localparam int LATD_W = LAT_W + 1;

    logic signed [LON_W-1:0]  lon1_c, lon2_c;
    logic signed [LAT_W-1:0]  lat1_c, lat2_c;
    logic signed [LATD_W-1:0] dlat;
    logic signed [LOND_W-1:0] dlon;

    logic [DEG_W-1:0]  dlat_deg_next, dlon_deg_next, lat1_deg_next, lat2_deg_next;
    logic [DEG_W-1:0]  dlat_deg_reg, dlon_deg_reg, lat1_deg_reg, lat2_deg_reg;
    logic [PROD_W-1:0] dlat_prod_next, dlon_prod_next, lat1_prod_next, lat2_prod_next;
    logic [PROD_W-1:0] dlat_prod_reg, dlon_prod_reg, lat1_prod_reg, lat2_prod_reg;
    logic [RAD_W-1:0]  hdlat, hdlon, rlat1, rlat2;
    arg_t              arg_dlat_next, arg_dlon_next, arg_c1_next, arg_c2_next;
    arg_t              arg_dlat_reg, arg_dlon_reg, arg_c1_reg, arg_c2_reg;
    logic              v1_reg, v2_reg, v3_reg;

    function automatic logic [DEG_W-1:0] to_deg(input logic signed [LOND_W-1:0] v);
        logic [LOND_W-1:0] m;
        logic [DEG_W:0]    s;
        m = v[LOND_W-1] ? LOND_W'(-v) : LOND_W'(v);
        s = ((DEG_W + 1)'(m) << DEG_UP) + (DEG_W + 1)'(DEG_RND);
        return DEG_W'(s >> DEG_DN);
    endfunction

    function automatic logic [RAD_W-1:0] to_rad(input logic [PROD_W-1:0] p, input int s);
        logic [PROD_W:0] t;
        t = (PROD_W + 1)'(p) + ((PROD_W + 1)'(1) << (s - 1));
        return RAD_W'(t >> s);
    endfunction

    function automatic arg_t fold(input logic [RAD_W-1:0] x);
        logic [RAD_W-1:0] xs;
        xs = (x > PI_Q30) ? PI_Q30 : x;
        return (xs > RAD_W'(HALF_PI_Q30)) ? ARG_W'(PI_Q30 - xs) : ARG_W'(xs);
    endfunction

    always_comb begin
        lon1_c = (lon_first > LON_LIM) ? LON_LIM :
                 (lon_first < -LON_LIM) ? -LON_LIM : lon_first;
        lon2_c = (lon_second > LON_LIM) ? LON_LIM :
                 (lon_second < -LON_LIM) ? -LON_LIM : lon_second;
        lat1_c = (lat_first > LAT_LIM) ? LAT_LIM :
                 (lat_first < -LAT_LIM) ? -LAT_LIM : lat_first;
        lat2_c = (lat_second > LAT_LIM) ? LAT_LIM :
                 (lat_second < -LAT_LIM) ? -LAT_LIM : lat_second;
        dlat = LATD_W'(lat2_c) - LATD_W'(lat1_c);
        dlon = LOND_W'(lon2_c) - LOND_W'(lon1_c);
        dlat_deg_next = to_deg(LOND_W'(dlat));
        dlon_deg_next = to_deg(dlon);
        lat1_deg_next = to_deg(LOND_W'(lat1_c));
        lat2_deg_next = to_deg(LOND_W'(lat2_c));
    end

    always_comb begin
        dlat_prod_next = PROD_W'(dlat_deg_reg) * PROD_W'(DEG2RAD_Q36);
        dlon_prod_next = PROD_W'(dlon_deg_reg) * PROD_W'(DEG2RAD_Q36);
        lat1_prod_next = PROD_W'(lat1_deg_reg) * PROD_W'(DEG2RAD_Q36);
        lat2_prod_next = PROD_W'(lat2_deg_reg) * PROD_W'(DEG2RAD_Q36);
    end

    always_comb begin
        hdlat = to_rad(dlat_prod_reg, Q_FRAC + 1);
        hdlon = to_rad(dlon_prod_reg, Q_FRAC + 1);
        rlat1 = to_rad(lat1_prod_reg, Q_FRAC);
        rlat2 = to_rad(lat2_prod_reg, Q_FRAC);
        arg_dlat_next = fold(hdlat);
        arg_dlon_next = fold(hdlon);
        arg_c1_next = (rlat1 < RAD_W'(HALF_PI_Q30)) ? ARG_W'(RAD_W'(HALF_PI_Q30) - rlat1) : '0;
        arg_c2_next = (rlat2 < RAD_W'(HALF_PI_Q30)) ? ARG_W'(RAD_W'(HALF_PI_Q30) - rlat2) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlat_deg_reg  <= dlat_deg_next;
            dlon_deg_reg  <= dlon_deg_next;
            lat1_deg_reg  <= lat1_deg_next;
            lat2_deg_reg  <= lat2_deg_next;
            dlat_prod_reg <= dlat_prod_next;
            dlon_prod_reg <= dlon_prod_next;
            lat1_prod_reg <= lat1_prod_next;
            lat2_prod_reg <= lat2_prod_next;
            arg_dlat_reg  <= arg_dlat_next;
            arg_dlon_reg  <= arg_dlon_next;
            arg_c1_reg    <= arg_c1_next;
            arg_c2_reg    <= arg_c2_next;
        end
    end

    assign out_valid      = v3_reg;
    assign arg_dlat       = arg_dlat_reg;
    assign arg_dlon       = arg_dlon_reg;
    assign arg_cos_first  = arg_c1_reg;
    assign arg_cos_second = arg_c2_reg;

endmodule

// ===== hdl/hvd_sin.sv =====
module hvd_sin (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hvd_pkg::arg_t x,
    output logic          out_valid,
    output hvd_pkg::q30_t y
);
    import hvd_pkg::*;

    logic [2*ARG_W-1:0]     sq;
    logic                   v0_reg;
    arg_t                   x0_reg;
    logic [SQ_W-1:0]        x2_0_reg;

    logic                   st_v  [SIN_STEPS+1];
    arg_t                   st_x  [SIN_STEPS+1];
    logic [SQ_W-1:0]        st_x2 [SIN_STEPS+1];
    q30_t                   st_t  [SIN_STEPS+1];

    logic [ARG_W+Q_W-1:0]   prod_f;
    logic [Q_W:0]           r_wide;
    q30_t                   y_next;
    q30_t                   y_reg;
    logic                   yv_reg;

    assign sq = (2 * ARG_W)'(x) * (2 * ARG_W)'(x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg   <= x;
            x2_0_reg <= sq[Q_FRAC +: SQ_W];
        end
    end

    assign st_v[0]  = v0_reg;
    assign st_x[0]  = x0_reg;
    assign st_x2[0] = x2_0_reg;
    assign st_t[0]  = ONE_Q30;

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_step
        localparam int K = SIN_K[i];
        localparam logic [SIN_M_W-1:0] M = SIN_M[i];

        logic                      va_reg, vb_reg;
        arg_t                      xa_reg, xb_reg;
        logic [SQ_W-1:0]           x2a_reg, x2b_reg;
        logic [SQ_W-1:0]           pa_reg;
        q30_t                      tb_reg;
        logic [SQ_W+Q_W-1:0]       prod_a;
        logic [SQ_W-1:0]           pa_next;
        logic [SQ_W+SIN_M_W-1:0]   prod_b;
        q30_t                      tb_next;

        always_comb begin
            prod_a  = (SQ_W + Q_W)'(st_x2[i]) * (SQ_W + Q_W)'(st_t[i]);
            pa_next = prod_a[Q_FRAC +: SQ_W];
            prod_b  = (SQ_W + SIN_M_W)'(pa_reg) * (SQ_W + SIN_M_W)'(M);
            tb_next = ONE_Q30 - Q_W'(prod_b >> K);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end else if (en) begin
                va_reg <= st_v[i];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                xa_reg  <= st_x[i];
                x2a_reg <= st_x2[i];
                pa_reg  <= pa_next;
                xb_reg  <= xa_reg;
                x2b_reg <= x2a_reg;
                tb_reg  <= tb_next;
            end
        end

        assign st_v[i+1]  = vb_reg;
        assign st_x[i+1]  = xb_reg;
        assign st_x2[i+1] = x2b_reg;
        assign st_t[i+1]  = tb_reg;
    end

    always_comb begin
        prod_f = (ARG_W + Q_W)'(st_x[SIN_STEPS]) * (ARG_W + Q_W)'(st_t[SIN_STEPS]);
        r_wide = prod_f[Q_FRAC +: Q_W+1];
        y_next = (r_wide > (Q_W + 1)'(ONE_Q30)) ? ONE_Q30 : Q_W'(r_wide);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yv_reg <= 1'b0;
        end else if (en) begin
            yv_reg <= st_v[SIN_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign out_valid = yv_reg;
    assign y         = y_reg;

endmodule

// ===== hdl/hvd_isqrt.sv =====
module hvd_isqrt (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hvd_pkg::q30_t val,
    output logic          out_valid,
    output hvd_pkg::q30_t root
);
    import hvd_pkg::*;

    localparam int N_W = Q_W + Q_FRAC;
    localparam int R_W = N_W + 1;

    logic           st_v [ISQRT_STEPS+1];
    logic [N_W-1:0] st_n [ISQRT_STEPS+1];
    logic [R_W-1:0] st_r [ISQRT_STEPS+1];

    assign st_v[0] = in_valid;
    assign st_n[0] = N_W'({val, {Q_FRAC{1'b0}}});
    assign st_r[0] = '0;

    for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_digit
        localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * (ISQRT_STEPS - 1 - j));

        logic [R_W-1:0] trial;
        logic [N_W-1:0] n_next, n_reg;
        logic [R_W-1:0] r_next, r_reg;
        logic           v_reg;

        always_comb begin
            trial = st_r[j] + BIT;
            if (R_W'(st_n[j]) >= trial) begin
                n_next = N_W'(R_W'(st_n[j]) - trial);
                r_next = (st_r[j] >> 1) + BIT;
            end else begin
                n_next = st_n[j];
                r_next = st_r[j] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= st_v[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg <= n_next;
                r_reg <= r_next;
            end
        end

        assign st_v[j+1] = v_reg;
        assign st_n[j+1] = n_reg;
        assign st_r[j+1] = r_reg;
    end

    assign out_valid = st_v[ISQRT_STEPS];
    assign root      = Q_W'(st_r[ISQRT_STEPS]);

endmodule

// ===== hdl/hvd_cordic.sv =====
module hvd_cordic (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hvd_pkg::q30_t x_in,
    input  hvd_pkg::q30_t y_in,
    output logic          out_valid,
    output hvd_pkg::ang_t angle
);
    import hvd_pkg::*;

    logic                       st_v [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] st_x [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] st_y [CORDIC_STEPS+1];
    ang_t                       st_z [CORDIC_STEPS+1];

    assign st_v[0] = in_valid;
    assign st_x[0] = CORDIC_W'(x_in);
    assign st_y[0] = CORDIC_W'(y_in);
    assign st_z[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam ang_t AT = ANGLE_ACC_W'(ATAN_Q30[i]);

        logic signed [CORDIC_W-1:0] xs, ys;
        logic signed [CORDIC_W-1:0] x_next, y_next, x_reg, y_reg;
        ang_t                       z_next, z_reg;
        logic                       v_reg;

        always_comb begin
            xs = st_x[i] >>> i;
            ys = st_y[i] >>> i;
            if (!st_y[i][CORDIC_W-1]) begin
                x_next = st_x[i] + ys;
                y_next = st_y[i] - xs;
                z_next = st_z[i] + AT;
            end else begin
                x_next = st_x[i] - ys;
                y_next = st_y[i] + xs;
                z_next = st_z[i] - AT;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= st_v[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
        end

        assign st_v[i+1] = v_reg;
        assign st_x[i+1] = x_reg;
        assign st_y[i+1] = y_reg;
        assign st_z[i+1] = z_reg;
    end

    assign out_valid = st_v[CORDIC_STEPS];
    assign angle     = st_z[CORDIC_STEPS];

endmodule

// ===== hdl/haversine_distance.sv =====
// Channel  Handshake          Payload
// s_       s_valid / s_ready  s_lon_first, s_lat_first, s_lon_second, s_lat_second
// m_       m_valid / m_ready  m_distance_km
//
// One transaction is accepted per cycle while the output queue is not full; its result
// passes the front, sine, 31-step square root and 31-step CORDIC stages to the queue.
// Synchronous active-low reset clears the stage valid bits and the output queue.
// A two-entry output queue holds results; the pipeline holds whenever the queue is full,
// so s_ready stays high while one result waits.
`include "haversine_distance_macros.svh"

module haversine_distance (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [hvd_pkg::LON_W-1:0] s_lon_first,
    input  logic signed [hvd_pkg::LAT_W-1:0] s_lat_first,
    input  logic signed [hvd_pkg::LON_W-1:0] s_lon_second,
    input  logic signed [hvd_pkg::LAT_W-1:0] s_lat_second,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [hvd_pkg::DIST_W-1:0]       m_distance_km
);
    import hvd_pkg::*;

    logic en;
    logic front_v;
    arg_t arg_dlat, arg_dlon, arg_c1, arg_c2;
    logic sin_v;
    q30_t s1, s2, c1, c2;

    logic [2*Q_W-1:0] s1sq_prod, c12_prod, s2sq_prod, term_prod;
    q30_t             s1sq_reg, c12_reg, s2sq_reg;
    logic             p1v_reg, p2v_reg;
    logic [Q_W:0]     a_sum;
    q30_t             a_next, a_reg, b_reg;

    logic sq_v;
    q30_t root_a, root_b;
    logic cordic_v;
    ang_t angle;

    logic [ARG_W-1:0]           zc;
    logic [NUM_W-1:0]           num_next, num_reg;
    logic [NUM_W:0]             w_sum;
    logic [DIST_QW-1:0]         w;
    logic [DIST_QW+DIST_RW-1:0] q_prod;
    logic [DIST_QW-1:0]         q_next, q_reg;
    logic                       d1v_reg, d2v_reg;
    logic [DIST_W-1:0]          dist_sat;

    logic              push, pop;
    logic [1:0]        cnt_next, cnt_reg;
    logic [DIST_W-1:0] e0_next, e0_reg, e1_next, e1_reg;

    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    hvd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_valid),
        .lon_first      (s_lon_first),
        .lat_first      (s_lat_first),
        .lon_second     (s_lon_second),
        .lat_second     (s_lat_second),
        .out_valid      (front_v),
        .arg_dlat       (arg_dlat),
        .arg_dlon       (arg_dlon),
        .arg_cos_first  (arg_c1),
        .arg_cos_second (arg_c2)
    );

    hvd_sin u_sin_dlat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(front_v),
        .x(arg_dlat), .out_valid(sin_v), .y(s1)
    );

    hvd_sin u_sin_dlon (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(front_v),
        .x(arg_dlon), .out_valid(), .y(s2)
    );

    hvd_sin u_cos_first (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(front_v),
        .x(arg_c1), .out_valid(), .y(c1)
    );

    hvd_sin u_cos_second (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(front_v),
        .x(arg_c2), .out_valid(), .y(c2)
    );

    always_comb begin
        s1sq_prod = (2 * Q_W)'(s1) * (2 * Q_W)'(s1);
        c12_prod  = (2 * Q_W)'(c1) * (2 * Q_W)'(c2);
        s2sq_prod = (2 * Q_W)'(s2) * (2 * Q_W)'(s2);
        term_prod = (2 * Q_W)'(c12_reg) * (2 * Q_W)'(s2sq_reg);
        a_sum     = (Q_W + 1)'(s1sq_reg) + (Q_W + 1)'(term_prod[Q_FRAC +: Q_W]);
        a_next    = (a_sum > (Q_W + 1)'(ONE_Q30)) ? ONE_Q30 : Q_W'(a_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
        end else if (en) begin
            p1v_reg <= sin_v;
            p2v_reg <= p1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1sq_reg <= s1sq_prod[Q_FRAC +: Q_W];
            c12_reg  <= c12_prod[Q_FRAC +: Q_W];
            s2sq_reg <= s2sq_prod[Q_FRAC +: Q_W];
            a_reg    <= a_next;
            b_reg    <= ONE_Q30 - a_next;
        end
    end

    hvd_isqrt u_sqrt_a (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p2v_reg),
        .val(a_reg), .out_valid(sq_v), .root(root_a)
    );

    hvd_isqrt u_sqrt_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p2v_reg),
        .val(b_reg), .out_valid(), .root(root_b)
    );

    hvd_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_v),
        .x_in      (root_b),
        .y_in      (root_a),
        .out_valid (cordic_v),
        .angle     (angle)
    );

    always_comb begin
        if (angle[ANGLE_ACC_W-1]) begin
            zc = '0;
        end else if (angle > ANGLE_ACC_W'(HALF_PI_Q30)) begin
            zc = HALF_PI_Q30;
        end else begin
            zc = ARG_W'(angle);
        end
        num_next = NUM_W'(zc) * NUM_W'(DIAM_TENTHS);
        w_sum    = (NUM_W + 1)'(num_reg) + (NUM_W + 1)'(DIST_HALF);
        w        = DIST_QW'(w_sum >> DIST_DS);
        q_prod   = (DIST_QW + DIST_RW)'(w) * (DIST_QW + DIST_RW)'(DIST_RECIP);
        q_next   = DIST_QW'(q_prod >> DIST_RK);
        dist_sat = (q_reg > DIST_QW'(DIST_MAX)) ? DIST_MAX : DIST_W'(q_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1v_reg <= 1'b0;
            d2v_reg <= 1'b0;
        end else if (en) begin
            d1v_reg <= cordic_v;
            d2v_reg <= d1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            q_reg   <= q_next;
        end
    end

    assign push = d2v_reg && en;
    assign pop  = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    e0_next = dist_sat;
                end else begin
                    e1_next = dist_sat;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                e0_next  = e1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    e0_next = dist_sat;
                end else begin
                    e0_next = e1_reg;
                    e1_next = dist_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_distance_km = e0_reg;

    `HVD_ASSERT(a_queue_bound, 1'b1, cnt_reg != 2'd3, "output queue count out of range")
    `HVD_ASSERT(a_no_overflow, push, cnt_reg != 2'd2, "transaction pushed into a full queue")
    `HVD_ASSERT_NEXT(a_pop_count, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1, "queue count not reduced after a pop")
    `HVD_ASSERT(a_dist_range, m_valid, m_distance_km <= DIST_HIGH, "distance beyond a half circumference")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import hvd_pkg::*;

    typedef struct {
        logic signed [LON_W-1:0] lon1;
        logic signed [LAT_W-1:0] lat1;
        logic signed [LON_W-1:0] lon2;
        logic signed [LAT_W-1:0] lat2;
    } coord_pair_t;

    localparam longint PI_C      = 64'd3373259426;
    localparam longint HALF_PI_C = 64'd1686629713;
    localparam longint ONE_C     = 64'd1 << 30;
    localparam longint DEG2RAD_C = 64'd1199381129;
    localparam longint LON_LIM_C = 64'd180 << ANGLE_FRAC_BITS;
    localparam longint LAT_LIM_C = 64'd90 << ANGLE_FRAC_BITS;
    localparam int     LATENCY   = 100;
    localparam longint CYCLE_LIMIT = 64'd2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [LON_W-1:0] s_lon_first = '0;
    logic signed [LAT_W-1:0] s_lat_first = '0;
    logic signed [LON_W-1:0] s_lon_second = '0;
    logic signed [LAT_W-1:0] s_lat_second = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DIST_W-1:0] m_distance_km;

    coord_pair_t pending_pairs[$];
    logic [DIST_W-1:0] expected_dist[$];
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_seen = 0;
    longint cycle_count = 0;
    bit     stim_done = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     hold_off = 0;
    int     stall_phase = 0;

    haversine_distance DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_lon_first(s_lon_first), .s_lat_first(s_lat_first),
        .s_lon_second(s_lon_second), .s_lat_second(s_lat_second),
        .m_valid(m_valid), .m_ready(m_ready), .m_distance_km(m_distance_km)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint to_q24(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        if (ANGLE_FRAC_BITS <= 24) return m << (24 - ANGLE_FRAC_BITS);
        return (m + (64'd1 << (ANGLE_FRAC_BITS - 25))) >> (ANGLE_FRAC_BITS - 24);
    endfunction

    function automatic longint to_radians(longint deg, int sh);
        logic [63:0] p;
        p = deg * DEG2RAD_C + (64'd1 << (sh - 1));
        return longint'(p >> sh);
    endfunction

    function automatic longint sine_q30(longint x);
        longint dens[6];
        longint x2, t, r;
        dens = '{156, 110, 72, 42, 20, 6};
        if (x > PI_C) x = PI_C;
        if (x > HALF_PI_C) x = PI_C - x;
        x2 = (x * x) >> 30;
        t = ONE_C;
        for (int i = 0; i < 6; i++) t = ONE_C - (((x2 * t) >> 30) / dens[i]);
        r = (x * t) >> 30;
        return (r > ONE_C) ? ONE_C : r;
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint arctan_step(int i);
        longint sum, term;
        int sh;
        sum = 0;
        if (i == 0) return 64'd843314857;
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= 60) break;
            term = (64'sd1 <<< (60 - sh)) / (2 * k + 1);
            sum = (k % 2 != 0) ? sum - term : sum + term;
        end
        return (sum + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle_km(coord_pair_t c);
        longint lon1, lat1, lon2, lat2, hdlat, hdlon, r1, r2;
        longint s1, s2, c1, c2, a, x, y, z, xs, ys, dv, dist_val;
        lon1 = clamp_to(longint'(c.lon1), LON_LIM_C);
        lat1 = clamp_to(longint'(c.lat1), LAT_LIM_C);
        lon2 = clamp_to(longint'(c.lon2), LON_LIM_C);
        lat2 = clamp_to(longint'(c.lat2), LAT_LIM_C);
        hdlat = to_radians(to_q24(lat2 - lat1), 31);
        hdlon = to_radians(to_q24(lon2 - lon1), 31);
        r1 = to_radians(to_q24(lat1), 30);
        r2 = to_radians(to_q24(lat2), 30);
        s1 = sine_q30(hdlat);
        s2 = sine_q30(hdlon);
        c1 = sine_q30(r1 < HALF_PI_C ? HALF_PI_C - r1 : 0);
        c2 = sine_q30(r2 < HALF_PI_C ? HALF_PI_C - r2 : 0);
        a = ((s1 * s1) >> 30) + ((((c1 * c2) >> 30) * ((s2 * s2) >> 30)) >> 30);
        if (a > ONE_C) a = ONE_C;
        y = root_floor(a << 30);
        x = root_floor((ONE_C - a) << 30);
        z = 0;
        for (int i = 0; i <= 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_C) z = HALF_PI_C;
        dv = 64'd10 << (30 - DIST_FRAC_BITS);
        dist_val = (z * 127456 + dv / 2) / dv;
        if (dist_val > 64'h7FFFFFFF) dist_val = 64'h7FFFFFFF;
        return DIST_W'(dist_val);
    endfunction

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    task automatic add_pair(longint a, longint b, longint c, longint d);
        coord_pair_t p;
        p.lon1 = LON_W'(a);
        p.lat1 = LAT_W'(b);
        p.lon2 = LON_W'(c);
        p.lat2 = LAT_W'(d);
        pending_pairs.push_back(p);
    endtask

    initial begin
        int kind;
        add_pair(0, 0, 0, 0);
        add_pair(LON_LIM_C, LAT_LIM_C, -LON_LIM_C, -LAT_LIM_C);
        add_pair(-LON_LIM_C, 0, LON_LIM_C, 0);
        add_pair(0, LAT_LIM_C, 0, -LAT_LIM_C);
        add_pair(0, LAT_LIM_C, 0, LAT_LIM_C);
        add_pair(-(64'd1 << 28), -(64'd1 << 27), (64'd1 << 28) - 1, (64'd1 << 27) - 1);
        add_pair((64'd1 << 28) - 1, (64'd1 << 27) - 1, -(64'd1 << 28), -(64'd1 << 27));
        add_pair(LON_LIM_C + 1, LAT_LIM_C + 1, -LON_LIM_C - 1, -LAT_LIM_C - 1);
        add_pair(0, 0, 64'd1, 0);
        add_pair(0, 0, 0, 64'd1);
        add_pair(-LON_LIM_C, 0, 0, 0);
        add_pair(0, 0, LON_LIM_C, 0);
        add_pair(64'd90 << 20, 0, -(64'd90 << 20), 0);
        add_pair(64'd170 << 20, 64'd45 << 20, -(64'd170 << 20), -(64'd45 << 20));
        add_pair(12345, -(64'd33 << 20), 54321, 64'd33 << 20);
        add_pair(-1, -1, -1, -1);
        for (int i = 0; i < 1300; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                add_pair(rand_span(LON_LIM_C), rand_span(LAT_LIM_C),
                         rand_span(LON_LIM_C), rand_span(LAT_LIM_C));
            end else if (kind < 8) begin
                add_pair(longint'($signed(LON_W'($urandom))),
                         longint'($signed(LAT_W'($urandom))),
                         longint'($signed(LON_W'($urandom))),
                         longint'($signed(LAT_W'($urandom))));
            end else begin
                longint lo, la;
                lo = rand_span(LON_LIM_C);
                la = rand_span(LAT_LIM_C);
                add_pair(lo, la, clamp_to(lo + rand_span(4096), LON_LIM_C),
                         clamp_to(la + rand_span(4096), LAT_LIM_C));
            end
        end
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count < 6) begin
            aresetn <= 1'b0;
        end else begin
            aresetn <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        coord_pair_t nxt;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_dist.push_back(great_circle_km(pending_pairs.pop_front()));
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    nxt = pending_pairs[0];
                    s_valid <= 1'b1;
                    s_lon_first <= nxt.lon1;
                    s_lat_first <= nxt.lat1;
                    s_lon_second <= nxt.lon2;
                    s_lat_second <= nxt.lat2;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            stall_phase <= stall_phase + 1;
            if (n_sent == 400 && hold_off == 0) begin
                hold_off <= 300;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
            end
            if (hold_off > 1 || (n_sent == 400 && hold_off == 0)) begin
                m_ready <= 1'b0;
            end else if (stall_phase % 512 < 128) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ((stall_phase * 7) % 11) > 3 && ($urandom_range(0, 4) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        logic [DIST_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            n_seen <= n_seen + 1;
            if (expected_dist.size() == 0) begin
                $error("unexpected transaction: distance_km %0d", m_distance_km);
                n_errors <= n_errors + 1;
            end else begin
                want = expected_dist.pop_front();
                if (want !== m_distance_km) begin
                    $error("distance_km: expected %0d, got %0d", want, m_distance_km);
                    n_errors <= n_errors + 1;
                end
            end
        end
    end

    initial begin
        wait (stim_done && pending_pairs.size() == 0 && !s_valid);
        wait (expected_dist.size() == 0);
        repeat (LATENCY) @(posedge aclk);
        $display("Checked %0d distances from %0d coordinate pairs,", n_seen, n_sent);
        $display("including clamped angles and a long output back-pressure stretch.");
        if (n_errors == 0 && expected_dist.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end
endmodule
